/* rtl/glyph_cache_lru_defines.svh */
// ----------------------------------------------------------------------------
// glyph_cache_lru_defines.svh
// Assertion macros used by glyph_cache_lru.
// ----------------------------------------------------------------------------
`ifndef GLYPH_CACHE_LRU_DEFINES_SVH
`define GLYPH_CACHE_LRU_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define GCL_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define GCL_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/gcl_pkg.sv */
// ----------------------------------------------------------------------------
// gcl_pkg
// Types and constants of the glyph cache.
// ----------------------------------------------------------------------------
package gcl_pkg;

   localparam logic [1:0]  FUNC_LOOKUP = 2'd0;
   localparam logic [1:0]  FUNC_INSERT = 2'd1;
   localparam logic [1:0]  FUNC_CLEAR  = 2'd2;

   localparam logic [15:0] EMPTY_TAG   = 16'hFFFF;
   localparam int          SLOT_W      = 4;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] char_code;
      logic [31:0] time_now;
      logic [31:0] bitmap_handle;
      logic [9:0]  glyph_width;
      logic [9:0]  glyph_height;
      logic [9:0]  row_pitch;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       found_handle;
      logic [9:0]        found_width;
      logic [9:0]        found_height;
      logic [9:0]        found_pitch;
      logic              evict_valid;
      logic [31:0]       evict_handle;
   } rsp_type;

   // Token that walks the cell row, one cell per cycle.
   typedef struct packed {
      logic        active;
      logic        found;
      logic [31:0] stamp;
      logic [31:0] handle;
      logic [9:0]  width;
      logic [9:0]  height;
      logic [9:0]  pitch;
   } scan_type;

   // Entry write broadcast to every cell.
   typedef struct packed {
      logic        en;
      logic [15:0] tag;
      logic [31:0] stamp;
      logic [31:0] handle;
      logic [9:0]  width;
      logic [9:0]  height;
      logic [9:0]  pitch;
   } wr_type;

endpackage

/* rtl/gcl_ifs.sv */
// ----------------------------------------------------------------------------
// gcl_ifs
// Valid/ready channels of the glyph cache.
// ----------------------------------------------------------------------------
interface gcl_req_if;
   logic             valid;
   logic             ready;
   gcl_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gcl_rsp_if;
   logic             valid;
   logic             ready;
   gcl_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/glyph_cache_lru.sv */
// ----------------------------------------------------------------------------
// glyph_cache_lru
// Fully associative glyph cache with oldest-timestamp replacement.
// ----------------------------------------------------------------------------
// Each entry lives in its own cell; the cells form a row and a scan token
// walks it one cell per clock, matching tags on a lookup (first hit wins,
// its stamp is refreshed), tracking the oldest stamp on an insert (lowest
// index on ties), or emptying tags and handles on a clear. From transfer to
// result an item goes through launching the token, the walk down the row and
// the posting of the result, during which an insert writes the victim entry;
// posting waits while the response register is still full. One item is in
// flight at a time; a new request transfers as soon as the previous result is
// posted, even if the response register has not yet been taken.
module glyph_cache_lru #(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   gcl_req_if.sink   req_chan,
   gcl_rsp_if.source rsp_chan
);
   import gcl_pkg::*;
   `include "glyph_cache_lru_defines.svh"

   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type        state_ff;
   req_type          item_ff;
   logic             start_ff;
   rsp_type          pend_ff;
   rsp_type          rsp_data_ff;
   logic             rsp_valid_ff;
   wr_type           wr_ff;
   logic [IDX_W-1:0] wr_idx_ff;

   scan_type         scan_bus [ENTRIES+1];
   logic [IDX_W-1:0] idx_bus  [ENTRIES+1];
   logic [ENTRIES-1:0] active_vec;

   scan_type         tail;
   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   rsp_type          result;
   logic             rsp_free;
   logic             req_xfer;
   logic             post_now;

   assign scan_bus[0] = scan_type'{active: start_ff, default: '0};
   assign idx_bus[0]  = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      gcl_cell #(.IDX_W(IDX_W), .INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .item     (item_ff),
         .scan_in  (scan_bus[i]),
         .idx_in   (idx_bus[i]),
         .wr       (wr_ff),
         .wr_idx   (wr_idx_ff),
         .scan_out (scan_bus[i+1]),
         .idx_out  (idx_bus[i+1])
      );
      assign active_vec[i] = scan_bus[i+1].active;
   end

   assign tail     = scan_bus[ENTRIES];
   assign tail_idx = idx_bus[ENTRIES];
   assign slot_ext = {{SLOT_W{1'b0}}, tail_idx};

   always_comb begin
      result = '0;
      if (item_ff.func == FUNC_LOOKUP && tail.found) begin
         result.hit          = 1'b1;
         result.slot         = slot_ext[SLOT_W-1:0];
         result.found_handle = tail.handle;
         result.found_width  = tail.width;
         result.found_height = tail.height;
         result.found_pitch  = tail.pitch;
      end else if (item_ff.func == FUNC_INSERT) begin
         result.slot         = slot_ext[SLOT_W-1:0];
         result.evict_valid  = (tail.handle != '0);
         result.evict_handle = tail.handle;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign post_now = (state_ff == ST_DONE) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_ff        <= '0;
         wr_idx_ff    <= '0;
      end else begin
         start_ff     <= req_xfer;
         wr_ff.en     <= (state_ff == ST_SCAN) && tail.active
                         && (item_ff.func == FUNC_INSERT);
         rsp_valid_ff <= post_now || (rsp_valid_ff && !rsp_chan.ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  item_ff  <= req_chan.data;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (tail.active) begin
                  pend_ff      <= result;
                  wr_ff.tag    <= item_ff.char_code;
                  wr_ff.stamp  <= item_ff.time_now;
                  wr_ff.handle <= item_ff.bitmap_handle;
                  wr_ff.width  <= item_ff.glyph_width;
                  wr_ff.height <= item_ff.glyph_height;
                  wr_ff.pitch  <= item_ff.row_pitch;
                  wr_idx_ff    <= tail_idx;
                  state_ff     <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_data_ff  <= pend_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   `GCL_ASSERT_NOW(a_one_token, 1'b1, $onehot0({active_vec, start_ff}), "more than one scan token")
   `GCL_ASSERT_NOW(a_tail_in_scan, tail.active, state_ff == ST_SCAN, "token left row outside scan")
   `GCL_ASSERT_NOW(a_write_in_done, wr_ff.en, state_ff == ST_DONE, "entry write outside done")
   `GCL_ASSERT_NEXT(a_post, post_now, rsp_valid_ff && (state_ff == ST_IDLE), "result not posted")

endmodule

/* rtl/gcl_cell.sv */
// ----------------------------------------------------------------------------
// gcl_cell
// One cache entry. Acts on the scan token as it passes and hands it on.
// ----------------------------------------------------------------------------
module gcl_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gcl_pkg::req_type      item,
   input  gcl_pkg::scan_type     scan_in,
   input  logic [IDX_W-1:0]      idx_in,
   input  gcl_pkg::wr_type       wr,
   input  logic [IDX_W-1:0]      wr_idx,
   output gcl_pkg::scan_type     scan_out,
   output logic [IDX_W-1:0]      idx_out
);
   import gcl_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [15:0]      tag_ff;
   logic [31:0]      stamp_ff;
   logic [31:0]      handle_ff;
   logic [9:0]       width_ff;
   logic [9:0]       height_ff;
   logic [9:0]       pitch_ff;
   scan_type         scan_ff;
   logic [IDX_W-1:0] idx_ff;

   logic     match;
   logic     pick;
   logic     clr;
   scan_type scan_in_nxt;
   logic [IDX_W-1:0] idx_in_nxt;

   always_comb begin
      match = scan_in.active && (item.func == FUNC_LOOKUP) && (item.char_code != EMPTY_TAG)
              && !scan_in.found && (tag_ff == item.char_code);
      pick  = scan_in.active && (item.func == FUNC_INSERT)
              && (!scan_in.found || (stamp_ff < scan_in.stamp));
      clr   = scan_in.active && (item.func == FUNC_CLEAR);
      scan_in_nxt = scan_in;
      idx_in_nxt  = idx_in;
      if (match || pick) begin
         scan_in_nxt.found  = 1'b1;
         scan_in_nxt.stamp  = stamp_ff;
         scan_in_nxt.handle = handle_ff;
         scan_in_nxt.width  = width_ff;
         scan_in_nxt.height = height_ff;
         scan_in_nxt.pitch  = pitch_ff;
         idx_in_nxt         = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff    <= EMPTY_TAG;
         stamp_ff  <= '0;
         handle_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         pitch_ff  <= '0;
         scan_ff   <= '0;
         idx_ff    <= '0;
      end else begin
         scan_ff <= scan_in_nxt;
         idx_ff  <= idx_in_nxt;
         if (clr) begin
            tag_ff    <= EMPTY_TAG;
            handle_ff <= '0;
         end
         if (match) begin
            stamp_ff <= item.time_now;
         end
         if (wr.en && (wr_idx == MY_IDX)) begin
            tag_ff    <= wr.tag;
            stamp_ff  <= wr.stamp;
            handle_ff <= wr.handle;
            width_ff  <= wr.width;
            height_ff <= wr.height;
            pitch_ff  <= wr.pitch;
         end
      end
   end

   assign scan_out = scan_ff;
   assign idx_out  = idx_ff;

endmodule

/* dv/tb_glyph_cache_lru.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_cache_lru
// Self-checking bench for the glyph cache. A queue-fed driver sends lookups,
// inserts, clears and unused codes; a clocked monitor predicts each result
// from its own copy of the entry table and compares every field in order.
// Both channels idle in random bursts; the receiver also holds off once for a
// long stretch, and the sender pauses after each batch until the cache has drained.
// ----------------------------------------------------------------------------
module tb_glyph_cache_lru;
   import gcl_pkg::*;

   localparam int         CACHE_DEPTH  = 16;
   localparam int         ID_POOL_SIZE = 24;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         LONG_HOLD    = 300;
   localparam int         HOLD_AFTER   = 300;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;

   gcl_req_if req_if ();
   gcl_rsp_if rsp_if ();

   assign req_if.valid = req_valid;
   assign req_if.data  = req_data;
   assign rsp_if.ready = rsp_ready;

   glyph_cache_lru #(.ENTRIES(CACHE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predicted entry table
   logic [15:0] tag_mem    [CACHE_DEPTH];
   logic [31:0] stamp_mem  [CACHE_DEPTH];
   logic [31:0] handle_mem [CACHE_DEPTH];
   logic [9:0]  width_mem  [CACHE_DEPTH];
   logic [9:0]  height_mem [CACHE_DEPTH];
   logic [9:0]  pitch_mem  [CACHE_DEPTH];

   req_type     req_backlog[$];
   rsp_type     awaited_results[$];
   rsp_type     want_rsp;
   logic        req_fire      = 1'b0;
   logic        steady_tail   = 1'b0;
   logic        long_hold_done = 1'b0;
   int unsigned send_gap      = 0;
   int unsigned stall_left    = 0;
   int unsigned results_seen  = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;
   logic [31:0] tick          = 32'd100;
   logic [15:0] id_pool [ID_POOL_SIZE];

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_type cache_access(input req_type r);
      rsp_type     o;
      int unsigned victim;
      logic [31:0] oldest;
      o = '0;
      case (r.func)
         FUNC_LOOKUP: begin
            if (r.char_code != EMPTY_TAG) begin
               for (int i = 0; i < CACHE_DEPTH; i++) begin
                  if (tag_mem[i] == r.char_code) begin
                     stamp_mem[i]   = r.time_now;
                     o.hit          = 1'b1;
                     o.slot         = SLOT_W'(i);
                     o.found_handle = handle_mem[i];
                     o.found_width  = width_mem[i];
                     o.found_height = height_mem[i];
                     o.found_pitch  = pitch_mem[i];
                     break;
                  end
               end
            end
         end
         FUNC_INSERT: begin
            victim = 0;
            oldest = stamp_mem[0];
            for (int i = 1; i < CACHE_DEPTH; i++) begin
               if (stamp_mem[i] < oldest) begin
                  oldest = stamp_mem[i];
                  victim = i;
               end
            end
            o.slot             = SLOT_W'(victim);
            o.evict_valid      = handle_mem[victim] != '0;
            o.evict_handle     = handle_mem[victim];
            tag_mem[victim]    = r.char_code;
            handle_mem[victim] = r.bitmap_handle;
            width_mem[victim]  = r.glyph_width;
            height_mem[victim] = r.glyph_height;
            pitch_mem[victim]  = r.row_pitch;
            stamp_mem[victim]  = r.time_now;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
               tag_mem[i]    = EMPTY_TAG;
               handle_mem[i] = '0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_fire     <= 1'b0;
         results_seen <= 0;
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            tag_mem[i]    = EMPTY_TAG;
            stamp_mem[i]  = '0;
            handle_mem[i] = '0;
            width_mem[i]  = '0;
            height_mem[i] = '0;
            pitch_mem[i]  = '0;
         end
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: 0x%0h", rsp_if.data));
            end else begin
               want_rsp = awaited_results.pop_front();
               check_field("hit",          32'(rsp_if.data.hit),
                           32'(want_rsp.hit));
               check_field("slot",         32'(rsp_if.data.slot),
                           32'(want_rsp.slot));
               check_field("found_handle", rsp_if.data.found_handle,
                           want_rsp.found_handle);
               check_field("found_width",  32'(rsp_if.data.found_width),
                           32'(want_rsp.found_width));
               check_field("found_height", 32'(rsp_if.data.found_height),
                           32'(want_rsp.found_height));
               check_field("found_pitch",  32'(rsp_if.data.found_pitch),
                           32'(want_rsp.found_pitch));
               check_field("evict_valid",  32'(rsp_if.data.evict_valid),
                           32'(want_rsp.evict_valid));
               check_field("evict_handle", rsp_if.data.evict_handle,
                           want_rsp.evict_handle);
            end
            results_seen <= results_seen + 1;
         end
         if (req_if.valid && req_if.ready)
            awaited_results.push_back(cache_access(req_if.data));
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (req_backlog.size() > 0) begin
            if (!steady_tail && $urandom_range(0, 9) == 0) begin
               req_valid <= 1'b0;
               send_gap  <= $urandom_range(0, 8);
            end else begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result ready: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
         long_hold_done <= 1'b1;
         stall_left     <= LONG_HOLD;
         rsp_ready      <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** glyph_cache_lru: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [1:0] f, input logic [15:0] id,
                                        input logic [31:0] now, input logic [31:0] hnd,
                                        input logic [9:0] w, input logic [9:0] h,
                                        input logic [9:0] p);
      req_type r;
      r.func          = f;
      r.char_code     = id;
      r.time_now      = now;
      r.bitmap_handle = hnd;
      r.glyph_width   = w;
      r.glyph_height  = h;
      r.row_pitch     = p;
      return r;
   endfunction

   task automatic queue_random(input int count);
      req_type     r;
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         r.func = pick < 58 ? FUNC_LOOKUP :
                  pick < 92 ? FUNC_INSERT :
                  pick < 96 ? FUNC_CLEAR  : FUNC_UNUSED;
         pick = $urandom_range(0, 99);
         r.char_code = pick < 85 ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)] :
                       pick < 95 ? 16'($urandom) : EMPTY_TAG;
         tick = tick + $urandom_range(0, 3);
         r.time_now      = $urandom_range(0, 19) == 0 ? 32'($urandom) : tick;
         r.bitmap_handle = $urandom_range(0, 9) == 0 ? 32'd0 : 32'($urandom);
         r.glyph_width   = 10'($urandom);
         r.glyph_height  = 10'($urandom);
         r.row_pitch     = 10'($urandom);
         req_backlog.push_back(r);
      end
   endtask

   task automatic wait_drained;
      while (req_backlog.size() != 0 || req_valid || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      for (int k = 0; k < ID_POOL_SIZE; k++)
         id_pool[k] = 16'($urandom_range(0, 16'hFFFE));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // misses on an empty cache, including the empty marker itself
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h0000, 32'd1, '0, '0, '0, '0));
      req_backlog.push_back(make_req(FUNC_LOOKUP, EMPTY_TAG, 32'd2, '0, '0, '0, '0));
      // field extremes
      req_backlog.push_back(make_req(FUNC_INSERT, 16'h0000, 32'd5, 32'hFFFF_FFFF,
                                     10'h3FF, 10'h3FF, 10'h3FF));
      req_backlog.push_back(make_req(FUNC_INSERT, 16'hFFFE, 32'hFFFF_FFFF, 32'h0,
                                     10'h000, 10'h000, 10'h000));
      // inserting the empty marker: stored but never found
      req_backlog.push_back(make_req(FUNC_INSERT, EMPTY_TAG, 32'd7, 32'hA5A5_5A5A,
                                     10'h2AA, 10'h155, 10'h3FF));
      req_backlog.push_back(make_req(FUNC_LOOKUP, EMPTY_TAG, 32'd8, '0, '0, '0, '0));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h0000, 32'd10, '0, '0, '0, '0));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF, '0, '0, '0, '0));
      // unused code leaves the table alone
      req_backlog.push_back(make_req(FUNC_UNUSED, 16'h0000, 32'd0, 32'h1234_5678,
                                     10'h3FF, 10'h3FF, 10'h3FF));
      // equal stamps: lowest index wins, then a nonzero handle is evicted
      req_backlog.push_back(make_req(FUNC_INSERT, 16'h1234, 32'd0, 32'h5A5A_A5A5,
                                     10'h155, 10'h2AA, 10'h001));
      req_backlog.push_back(make_req(FUNC_INSERT, 16'h4321, 32'd0, 32'h0000_0001,
                                     10'h001, 10'h200, 10'h100));
      req_backlog.push_back(make_req(FUNC_INSERT, 16'h8000, 32'd3, 32'h8000_0000,
                                     10'h200, 10'h001, 10'h155));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h4321, 32'd12, '0, '0, '0, '0));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h8000, 32'd13, '0, '0, '0, '0));
      // clear keeps stamps and dimensions, drops tags and handles
      req_backlog.push_back(make_req(FUNC_CLEAR, 16'h0000, 32'd14, 32'hFFFF_FFFF,
                                     10'h3FF, 10'h3FF, 10'h3FF));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h0000, 32'd15, '0, '0, '0, '0));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h4321, 32'd16, '0, '0, '0, '0));
      req_backlog.push_back(make_req(FUNC_INSERT, 16'h7FFF, 32'd20, 32'hDEAD_0000,
                                     10'h0F0, 10'h00F, 10'h3C3));
      req_backlog.push_back(make_req(FUNC_LOOKUP, 16'h7FFF, 32'd21, '0, '0, '0, '0));
      wait_drained();

      queue_random(400);
      wait_drained();
      queue_random(400);
      wait_drained();
      steady_tail <= 1'b1;
      queue_random(200);
      wait_drained();
      repeat (2 * CACHE_DEPTH + 8) @(negedge clock);

      if (fail_count == 0)
         $display("** glyph_cache_lru: PASSED **");
      else
         $display("** glyph_cache_lru: FAILED **");
      $finish;
   end

endmodule
